### design/vn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// shared widths and stage types for the vector normalizer
// ----------------------------------------------------------------------------
package vn_pkg;

	localparam int LANES   = 4;
	localparam int ROOT_W  = 17;
	localparam int SUM_W   = 33;
	localparam int NUM_W   = 60;
	localparam int ACC_W   = 70;
	localparam int CROSS_W = 51;
	localparam int LSQ_W   = 36;

	typedef struct packed {
		logic [SUM_W-1:0]                  s;
		logic [LSQ_W-1:0]                  lp;
		logic [ROOT_W-1:0]                 lr;
		logic [LANES-1:0]                  neg;
		logic [LANES-1:0][NUM_W-1:0]       n;
		logic [LANES-1:0][ACC_W-1:0]       p;
		logic [LANES-1:0][CROSS_W-1:0]     t;
		logic [LANES-1:0][ROOT_W-1:0]      q;
		logic                              zero;
	} iter_t;

endpackage

### design/vn_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_in_if
// request channel carrying one four-component vector
// ----------------------------------------------------------------------------
interface vn_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] comp_x;
	logic signed [15:0] comp_y;
	logic signed [15:0] comp_z;
	logic signed [15:0] comp_w;

	modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
	modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

### design/vn_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_out_if
// result channel carrying the unit vector and magnitude
// ----------------------------------------------------------------------------
interface vn_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] unit_x;
	logic signed [15:0] unit_y;
	logic signed [15:0] unit_z;
	logic signed [15:0] unit_w;
	logic [16:0]        length_q;
	logic               zero_vector;

	modport source (output valid, unit_x, unit_y, unit_z, unit_w, length_q, zero_vector,
		input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, unit_w, length_q, zero_vector,
		output ready);
endinterface

### design/vec4_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_normalize
// four-component fixed-point vector normalization
// ----------------------------------------------------------------------------
// pipeline: 2 setup stages (squares, sum) followed by 17 root-bit stages
// throughput: one request per cycle while the result is not stalled; each root-bit stage resolves one root bit per lane
// stall: the whole pipeline holds while the result waits, nothing is lost
// reset: arst_n clears all stage valid bits, payload is not reset
// ----------------------------------------------------------------------------
module vec4_normalize import vn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	vn_in_if.sink     vec_in,
	vn_out_if.source  vec_out
);

	logic                          adv;
	logic                          valid_s1;
	logic [LANES-1:0][31:0]        sq_s1;
	logic [LANES-1:0]              neg_s1;
	logic                          valid_s2;
	iter_t                         init_s2;
	logic [ROOT_W-1:0]             valid_it_q;
	iter_t                         it_q [ROOT_W];
	iter_t                         nxt [ROOT_W];
	logic [LANES-1:0][15:0]        mag;
	logic [LANES-1:0]              negc;
	logic [LANES-1:0][15:0]        raw;
	logic [SUM_W-1:0]              sum;
	logic [LANES-1:0][15:0]        unit;
	iter_t                         last;

	assign adv = !vec_out.valid || vec_out.ready;
	assign vec_in.ready = adv;

	assign raw[0] = vec_in.comp_x;
	assign raw[1] = vec_in.comp_y;
	assign raw[2] = vec_in.comp_z;
	assign raw[3] = vec_in.comp_w;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			negc[i] = raw[i][15];
			mag[i]  = raw[i][15] ? 16'(~raw[i] + 16'd1) : raw[i];
		end
	end

	// a magnitude of 0x8000 is read as 32768 by the unsigned multiply
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				sq_s1[i] <= 32'(mag[i]) * 32'(mag[i]);
			end
			neg_s1 <= negc;
		end
	end

	assign sum = SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2])
		+ SUM_W'(sq_s1[3]);

	always_ff @(posedge clk) begin
		if (adv) begin
			init_s2.s    <= sum;
			init_s2.lp   <= '0;
			init_s2.lr   <= '0;
			init_s2.neg  <= neg_s1;
			init_s2.p    <= '0;
			init_s2.t    <= '0;
			init_s2.q    <= '0;
			init_s2.zero <= (sum == '0);
			for (int i = 0; i < LANES; i++) begin
				init_s2.n[i] <= NUM_W'(sq_s1[i]) << 28;
			end
		end
	end

	// one root bit per stage: magnitude root and the four quotient roots
	always_comb begin
		iter_t             cur;
		logic [LSQ_W-1:0]  lc;
		logic [ACC_W-1:0]  pc;
		for (int k = 0; k < ROOT_W; k++) begin
			cur = (k == 0) ? init_s2 : it_q[(k == 0) ? 0 : k - 1];
			lc = cur.lp + (LSQ_W'(cur.lr) << (ROOT_W - k))
				+ (LSQ_W'(1) << (2 * (ROOT_W - 1 - k)));
			if (lc <= LSQ_W'(cur.s)) begin
				cur.lp = lc;
				cur.lr = cur.lr | (ROOT_W'(1) << (ROOT_W - 1 - k));
			end
			for (int i = 0; i < LANES; i++) begin
				pc = cur.p[i] + (ACC_W'(cur.t[i]) << (ROOT_W - k))
					+ (ACC_W'(cur.s) << (2 * (ROOT_W - 1 - k)));
				if (pc <= ACC_W'(cur.n[i])) begin
					cur.p[i] = pc;
					cur.t[i] = cur.t[i] + (CROSS_W'(cur.s) << (ROOT_W - 1 - k));
					cur.q[i] = cur.q[i] | (ROOT_W'(1) << (ROOT_W - 1 - k));
				end
			end
			nxt[k] = cur;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < ROOT_W; k++) begin
				it_q[k] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_it_q <= '0;
		end else if (adv) begin
			valid_s1   <= vec_in.valid;
			valid_s2   <= valid_s1;
			valid_it_q <= {valid_it_q[ROOT_W-2:0], valid_s2};
		end
	end

	assign last = it_q[ROOT_W-1];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (last.zero) begin
				unit[i] = '0;
			end else if (last.neg[i]) begin
				unit[i] = 16'(~last.q[i] + ROOT_W'(1));
			end else begin
				unit[i] = last.q[i][15:0];
			end
		end
	end

	assign vec_out.valid       = valid_it_q[ROOT_W-1];
	assign vec_out.unit_x      = unit[0];
	assign vec_out.unit_y      = unit[1];
	assign vec_out.unit_z      = unit[2];
	assign vec_out.unit_w      = unit[3];
	assign vec_out.length_q    = last.lr;
	assign vec_out.zero_vector = last.zero;

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		vec_out.valid && vec_out.zero_vector |-> vec_out.length_q == '0 &&
		vec_out.unit_x == '0 && vec_out.unit_w == '0)
		else $error("zero vector with nonzero result");

	a_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		vec_out.valid && !vec_out.zero_vector |-> vec_out.length_q != '0)
		else $error("nonzero vector with zero length");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		vec_out.valid |-> (vec_out.unit_x <= 16'sd16384 && vec_out.unit_x >= -16'sd16384))
		else $error("unit component out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vec_out.valid && !vec_out.ready |=> vec_out.valid && $stable(last.lr))
		else $error("pipeline advanced under stall");

endmodule
